[rtl/core/fcca_pkg.sv]
`default_nettype none

package fcca_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CRC_W = 16;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

   // held-back byte count in check mode, saturates at two
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_FULL = 2'd2;

   // number of result bytes produced by one input byte
   localparam logic [1:0] RSP_ONE = 2'd1;
   localparam logic [1:0] RSP_TWO = 2'd2;
   localparam logic [1:0] RSP_THREE = 2'd3;

   localparam logic MODE_CHECK = 1'b0;
   localparam logic MODE_APPEND = 1'b1;

   typedef struct packed {
      logic [1:0] count;
      logic [BYTE_W-1:0] data;
      logic last;
      logic check_valid;
      logic crc_ok;
      logic too_short;
      logic [CRC_W-1:0] crc;
   } result_type;

   // one byte of CRC-16, MSB first, unrolled
   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] c_in,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = c_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/fcca_frame.sv]
`default_nettype none

module fcca_frame
   import fcca_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              mode,
   input  wire logic              clear,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              is_last,
   output result_type             result
);

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] older_ff, older_in;
   logic [1:0] seen_ff, seen_in;

   logic [CRC_W-1:0] crc_gen;
   logic [CRC_W-1:0] crc_chk;

   always_comb begin
      crc_gen = crc16_step(crc_ff, data_byte);
      // the byte two places back is now known to be body, fold it in
      crc_chk = (seen_ff == SEEN_FULL) ? crc16_step(crc_ff, older_ff) : crc_ff;

      result = '0;
      result.data = data_byte;
      crc_in = crc_ff;
      prev_in = prev_ff;
      older_in = older_ff;
      seen_in = seen_ff;

      if (mode == MODE_APPEND) begin
         result.count = is_last ? RSP_THREE : RSP_ONE;
         result.crc = crc_gen;
         crc_in = crc_gen;
      end else begin
         result.count = RSP_ONE;
         result.crc = crc_chk;
         result.last = is_last;
         result.check_valid = is_last;
         result.too_short = is_last && (seen_ff == SEEN_NONE);
         result.crc_ok = is_last && (seen_ff != SEEN_NONE) &&
                         (crc_chk == {prev_ff, data_byte});
         crc_in = crc_chk;
         older_in = prev_ff;
         prev_in = data_byte;
         if (seen_ff != SEEN_FULL) begin
            seen_in = seen_ff + 2'd1;
         end
      end

      if (is_last) begin
         crc_in = CRC_INIT;
         prev_in = '0;
         older_in = '0;
         seen_in = SEEN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         crc_ff <= CRC_INIT;
         prev_ff <= '0;
         older_ff <= '0;
         seen_ff <= SEEN_NONE;
      end else if (step) begin
         crc_ff <= crc_in;
         prev_ff <= prev_in;
         older_ff <= older_in;
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/frame_crc16_check_append.sv]
// Data path: a result byte comes from its input transaction through the input register,
//   then the result register.
// Throughput: one byte per cycle while the output accepts; in append mode the last body
//   byte yields three result bytes and holds the input side until the trailer is taken.
// The output register drains while the next byte waits in the input register.
// Reset (synchronous, active high) selects check mode and clears the frame state.
`default_nettype none

module frame_crc16_check_append
   import fcca_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic              req_tlast,   // is_last
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                   rsp_tlast,   // out_last
   output logic [2:0]             rsp_tuser,   // [0] check_valid, [1] crc_ok, [2] too_short
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data     // mode
);

   logic mode_ff;

   logic in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic in_last_ff;

   logic [1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;
   logic [2:0] rsp_user_ff, rsp_user_in;
   logic [CRC_W-1:0] crc_ff, crc_in;

   logic csr_write;
   logic req_take;
   logic rsp_take;
   logic out_free;
   logic advance;
   result_type res;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign rsp_tvalid = (rsp_cnt_ff != 2'd0);
   assign rsp_tdata = rsp_byte_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_user_ff;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign out_free = (rsp_cnt_ff == 2'd0) || (rsp_take && rsp_cnt_ff == RSP_ONE);
   assign advance = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || advance;
   assign req_take = req_tvalid && req_tready;

   fcca_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .clear     (csr_write),
      .step      (advance),
      .data_byte (in_byte_ff),
      .is_last   (in_last_ff),
      .result    (res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_cnt_in = rsp_cnt_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_user_in = rsp_user_ff;
      crc_in = crc_ff;
      if (advance) begin
         rsp_cnt_in = res.count;
         rsp_byte_in = res.data;
         rsp_last_in = res.last;
         rsp_user_in = {res.too_short, res.crc_ok, res.check_valid};
         crc_in = res.crc;
      end else if (rsp_take) begin
         rsp_cnt_in = rsp_cnt_ff - 2'd1;
         rsp_user_in = '0;
         // appended trailer: high byte, then low byte closing the frame
         rsp_byte_in = (rsp_cnt_ff == RSP_THREE) ? crc_ff[CRC_W-1:BYTE_W]
                                                  : crc_ff[BYTE_W-1:0];
         rsp_last_in = (rsp_cnt_ff == RSP_TWO);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CHECK;
         in_vld_ff <= 1'b0;
         rsp_cnt_ff <= 2'd0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_data;
         end
         in_vld_ff <= in_vld_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
      crc_ff <= crc_in;
   end

   a_trailer_no_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_cnt_ff == RSP_THREE || rsp_cnt_ff == RSP_TWO) |-> (rsp_user_ff == 3'b000))
      else $error("verdict flags set on a byte ahead of appended trailer");

   a_trailer_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_cnt_ff == RSP_THREE || rsp_cnt_ff == RSP_TWO) |-> !rsp_last_ff)
      else $error("frame end flagged before appended trailer is done");

   a_trailer_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_cnt_ff == RSP_THREE) |=>
         (rsp_cnt_ff == RSP_TWO && rsp_tdata == $past(crc_ff[CRC_W-1:BYTE_W])))
      else $error("CRC high byte not presented after last body byte");

   a_flags_need_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_user_ff[0]) |-> (rsp_user_ff[2:1] == 2'b00))
      else $error("crc_ok or too_short set without check_valid");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("waiting input byte lost or changed");

endmodule

`default_nettype wire
